// ===== sv/idq_pkg.sv =====
// shared constants, types and ring helpers for the input-restricted deque
package idq_pkg;

    // ring geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W = 32;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes carried on s_tuser
    typedef enum logic [2:0] {
        KIND_ENQ_REAR   = 3'd0,
        KIND_DEQ_FRONT  = 3'd1,
        KIND_DEQ_REAR   = 3'd2,
        KIND_PEEK_FRONT = 3'd3,
        KIND_PEEK_REAR  = 3'd4,
        KIND_SEARCH     = 3'd5
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // request from the sequencer to the entry store
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } store_req_t;

    // next slot around the ring
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(DEPTH - 1))
            r = '0;
        else
            r = p + IDX_W'(1);
        return r;
    endfunction

    // previous slot around the ring
    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == '0)
            r = IDX_W'(DEPTH - 1);
        else
            r = p - IDX_W'(1);
        return r;
    endfunction

endpackage

// ===== sv/idq_store.sv =====
// entry store: one write port and one registered read port
module idq_store
    import idq_pkg::*;
(
    input  logic             clk,
    input  store_req_t       req,
    output logic [VAL_W-1:0] rd_data
);

    logic [VAL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== sv/idq_seq.sv =====
// sequencer: ring pointers, shared compare scan and result register
module idq_seq
    import idq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] cap,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [2:0]       s_kind,
    input  logic [VAL_W-1:0] s_value,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [VAL_W-1:0] m_data,
    output logic [1:0]       m_status,
    output logic             m_found,
    output store_req_t       req,
    input  logic [VAL_W-1:0] rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_LAND,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] res_data_reg, res_data_next;
    status_t          res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_data_reg, m_data_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_found_reg, m_found_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             issue_more;
    logic             match;
    logic             scan_end;
    logic [CMP_W-1:0] cap_eff;
    kind_t            in_kind;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_kind  = kind_t'(s_kind);

    // effective capacity, clamped to the ring size
    assign cap_eff = (CMP_W'(cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap);
    assign full    = (CMP_W'(count_reg) >= cap_eff);
    assign empty   = (count_reg == '0);

    // shared compare unit and scan progress
    assign issue_more = (issued_reg != count_reg);
    assign match      = cmp_vld_reg && (rd_data == value_reg);
    assign scan_end   = match || (!issue_more && !cmp_vld_reg);

    assign m_tvalid = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;

    // next-state and store request
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        ptr_next        = ptr_reg;
        issued_next     = issued_reg;
        cmp_vld_next    = 1'b0;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;

        req.wr_en   = 1'b0;
        req.wr_addr = tail_reg;
        req.wr_data = value_reg;
        req.rd_en   = 1'b0;
        req.rd_addr = ptr_reg;

        // output register drains independently
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = in_kind;
                    value_next      = s_value;
                    ptr_next        = head_reg;
                    issued_next     = '0;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    case (in_kind)
                        KIND_ENQ_REAR:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        KIND_DEQ_FRONT, KIND_DEQ_REAR, KIND_PEEK_FRONT, KIND_PEEK_REAR:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // one entry read per cycle, compared the cycle after
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                    if (kind_reg == KIND_SEARCH)
                    begin
                        res_found_next = match;
                    end
                    else if (match)
                    begin
                        res_status_next = ST_DUP;
                    end
                    else
                    begin
                        req.wr_en  = 1'b1;
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (issue_more)
                begin
                    req.rd_en    = 1'b1;
                    ptr_next     = ring_next(ptr_reg);
                    issued_next  = issued_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                end
            end

            // single read for dequeue and peek, pointers move here
            S_READ:
            begin
                req.rd_en  = 1'b1;
                state_next = S_LAND;
                case (kind_reg)
                    KIND_DEQ_FRONT:
                    begin
                        req.rd_addr = head_reg;
                        head_next   = ring_next(head_reg);
                        count_next  = count_reg - CNT_W'(1);
                    end
                    KIND_PEEK_FRONT:
                    begin
                        req.rd_addr = head_reg;
                    end
                    KIND_DEQ_REAR:
                    begin
                        req.rd_addr = ring_prev(tail_reg);
                        tail_next   = ring_prev(tail_reg);
                        count_next  = count_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        req.rd_addr = ring_prev(tail_reg);
                    end
                endcase
            end

            S_LAND:
            begin
                res_data_next = rd_data;
                state_next    = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_data_reg;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_ENQ_REAR;
            value_reg      <= '0;
            ptr_reg        <= '0;
            issued_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            res_data_reg   <= '0;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_status_reg   <= '0;
            m_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            value_reg      <= value_next;
            ptr_reg        <= ptr_next;
            issued_reg     <= issued_next;
            cmp_vld_reg    <= cmp_vld_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            res_data_reg   <= res_data_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
            m_status_reg   <= m_status_next;
            m_found_reg    <= m_found_next;
        end
    end

endmodule

// ===== sv/input_restricted_deque_unit.sv =====
// Input-restricted deque: enqueue at rear, dequeue or peek at either end, search.
// Enqueue and search scan the stored entries for the value, one after another,
// using the single compare unit that checks one stored entry per cycle.
// Dequeue and peek make one registered store read; full, empty and unused kinds do no access.
// One item at a time: the next transfer is taken the cycle after the result is loaded.
// Reset (rst_n low, asynchronous) empties the queue and sets the capacity to 16.
module input_restricted_deque_unit
    import idq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,     // capacity_limit
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,       // [31:0] value
    input  logic [2:0]       s_tuser,       // [2:0] kind
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,       // [31:0] data
    output logic [2:0]       m_tuser        // [1:0] status, [2] found
);

    logic [CAP_W-1:0] cap_reg;
    store_req_t       req;
    logic [VAL_W-1:0] rd_data;
    logic [1:0]       res_status;
    logic             res_found;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    idq_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    idq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cap      (cap_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_value  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_data   (m_tdata),
        .m_status (res_status),
        .m_found  (res_found),
        .req      (req),
        .rd_data  (rd_data)
    );

    // pack result side-band
    assign m_tuser = {res_found, res_status};

endmodule
